/* hw/rtl/obspass_pkg.sv */
// ----------------------------------------------------------------------------
// obspass_pkg
// Shared types and constants for the obstacle avoid pass sequencer.
// ----------------------------------------------------------------------------
package obspass_pkg;

   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 16;
   localparam int unsigned VOTE_CNT_W = 4;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_FRONT_STOP     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SIDE_CLEAR     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FWD_DUTY       = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PIVOT          = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_STRAIGHT_ONE   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_STRAIGHT_TWO   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_STRAIGHT_THREE = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_FINAL_ALIGN    = 3'd7;

   // modes
   localparam logic [1:0] MODE_IDLE   = 2'd0;
   localparam logic [1:0] MODE_CRUISE = 2'd1;
   localparam logic [1:0] MODE_VOTE   = 2'd2;
   localparam logic [1:0] MODE_PASS   = 2'd3;

   // direction pin codes
   localparam logic [1:0] DIR_OFF = 2'd0;
   localparam logic [1:0] DIR_FWD = 2'd1;
   localparam logic [1:0] DIR_REV = 2'd2;

   // pass stages
   localparam logic [2:0] STAGE_PIVOT1    = 3'd0;
   localparam logic [2:0] STAGE_STRAIGHT1 = 3'd1;
   localparam logic [2:0] STAGE_PIVOT2    = 3'd2;
   localparam logic [2:0] STAGE_STRAIGHT2 = 3'd3;
   localparam logic [2:0] STAGE_PIVOT3    = 3'd4;
   localparam logic [2:0] STAGE_STRAIGHT3 = 3'd5;
   localparam logic [2:0] STAGE_ALIGN     = 3'd6;
   localparam logic [2:0] STAGE_DONE      = 3'd7;

   localparam logic [31:0] STARTUP_WAIT_MS = 32'd1000;
   localparam logic [31:0] VOTE_GAP_MS     = 32'd25;
   localparam logic [7:0]  FULL_DUTY       = 8'd255;

   localparam logic [VOTE_CNT_W-1:0] VOTE_SAMPLES  = 4'd10;
   localparam logic [VOTE_CNT_W-1:0] VOTE_MIN_HITS = 4'd6;

   typedef struct packed {
      logic [14:0] front_stop_us;
      logic [14:0] side_clear_us;
      logic [7:0]  fwd_duty;
      logic [15:0] turn_ms;
      logic [15:0] straight_one_ms;
      logic [15:0] straight_two_ms;
      logic [15:0] straight_three_ms;
      logic [15:0] align_ms;
   } cfg_type;

   typedef struct packed {
      logic [31:0] now_ms;
      logic        button_level;
      logic [14:0] echo_front_us;
      logic [14:0] echo_left_us;
      logic [14:0] echo_right_us;
   } item_type;

   typedef struct packed {
      logic                  system_on;
      logic                  prev_button;
      logic [1:0]            mode;
      logic [2:0]            stage;
      logic                  side_right;
      logic [31:0]           stage_start_ms;
      logic                  voting_active;
      logic [VOTE_CNT_W-1:0] vote_count;
      logic [VOTE_CNT_W-1:0] front_votes;
      logic [VOTE_CNT_W-1:0] left_votes;
      logic [VOTE_CNT_W-1:0] right_votes;
      logic [31:0]           last_vote_ms;
      logic                  vote_taken;
      logic [1:0]            left_dir;
      logic [1:0]            right_dir;
      logic                  led;
   } state_type;

   typedef struct packed {
      logic [7:0] left_pwm;
      logic [1:0] left_dir;
      logic [7:0] right_pwm;
      logic [1:0] right_dir;
      logic       led_on;
      logic [1:0] mode_now;
      logic [2:0] pass_stage_now;
      logic       pass_to_right;
   } result_type;

   // an echo of zero means nothing seen
   function automatic logic is_blocked(input logic [14:0] us, input logic [14:0] lim);
      return (us != 15'd0) && (us <= lim);
   endfunction

endpackage

/* hw/rtl/obspass_csr.sv */
// ----------------------------------------------------------------------------
// obspass_csr
// Configuration register file, write only.
// ----------------------------------------------------------------------------
module obspass_csr
   import obspass_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output cfg_type               cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_FRONT_STOP:     cfg_in.front_stop_us     = csr_wdata[14:0];
            CSR_SIDE_CLEAR:     cfg_in.side_clear_us     = csr_wdata[14:0];
            CSR_FWD_DUTY:       cfg_in.fwd_duty          = csr_wdata[7:0];
            CSR_PIVOT:          cfg_in.turn_ms           = csr_wdata;
            CSR_STRAIGHT_ONE:   cfg_in.straight_one_ms   = csr_wdata;
            CSR_STRAIGHT_TWO:   cfg_in.straight_two_ms   = csr_wdata;
            CSR_STRAIGHT_THREE: cfg_in.straight_three_ms = csr_wdata;
            CSR_FINAL_ALIGN:    cfg_in.align_ms          = csr_wdata;
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.front_stop_us     <= 15'd1632;
         cfg_ff.side_clear_us     <= 15'd1632;
         cfg_ff.fwd_duty          <= 8'd255;
         cfg_ff.turn_ms           <= 16'd850;
         cfg_ff.straight_one_ms   <= 16'd1100;
         cfg_ff.straight_two_ms   <= 16'd1400;
         cfg_ff.straight_three_ms <= 16'd1100;
         cfg_ff.align_ms          <= 16'd650;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* hw/rtl/obspass_step.sv */
// ----------------------------------------------------------------------------
// obspass_step
// One control tick: next sequencer state and the motor/lamp result.
// ----------------------------------------------------------------------------
module obspass_step
   import obspass_pkg::*;
(
   input  cfg_type    cfg,
   input  item_type   item,
   input  state_type  cur,
   output state_type  nxt,
   output result_type res
);

   state_type   st;
   logic [7:0]  duty;
   logic [31:0] elapsed;
   logic [31:0] gap;
   logic        f_blk;
   logic        l_blk;
   logic        r_blk;
   logic        vf;
   logic        vl;
   logic        vr;
   logic        go_pass;

   function automatic state_type clear_votes(input state_type s);
      state_type r;
      r               = s;
      r.voting_active = 1'b0;
      r.vote_count    = '0;
      r.front_votes   = '0;
      r.left_votes    = '0;
      r.right_votes   = '0;
      r.vote_taken    = 1'b0;
      return r;
   endfunction

   assign elapsed = item.now_ms - cur.stage_start_ms;
   assign gap     = item.now_ms - cur.last_vote_ms;
   assign f_blk   = is_blocked(item.echo_front_us, cfg.front_stop_us);
   assign l_blk   = is_blocked(item.echo_left_us, cfg.side_clear_us);
   assign r_blk   = is_blocked(item.echo_right_us, cfg.side_clear_us);

   always_comb begin
      st      = cur;
      duty    = 8'd0;
      vf      = 1'b0;
      vl      = 1'b0;
      vr      = 1'b0;
      go_pass = 1'b0;
      if (item.now_ms >= STARTUP_WAIT_MS) begin
         // falling edge of the active-low button toggles run/stop
         if (st.prev_button && !item.button_level) begin
            st.system_on = !st.system_on;
            if (!st.system_on) begin
               st.mode = MODE_IDLE;
               st.led  = 1'b0;
            end else begin
               st      = clear_votes(st);
               st.mode = MODE_CRUISE;
               st.led  = 1'b1;
            end
         end
         st.prev_button = item.button_level;
         if (st.system_on) begin
            case (st.mode)
               MODE_CRUISE: begin
                  if (f_blk || l_blk || r_blk) begin
                     st.mode = MODE_VOTE;
                  end else begin
                     st.left_dir  = DIR_FWD;
                     st.right_dir = DIR_FWD;
                     duty         = cfg.fwd_duty;
                  end
               end
               MODE_VOTE: begin
                  if (!st.voting_active) begin
                     st               = clear_votes(st);
                     st.voting_active = 1'b1;
                  end
                  if (!st.vote_taken || gap >= VOTE_GAP_MS) begin
                     st.last_vote_ms = item.now_ms;
                     st.vote_taken   = 1'b1;
                     if (f_blk) st.front_votes = st.front_votes + 4'd1;
                     if (l_blk) st.left_votes  = st.left_votes + 4'd1;
                     if (r_blk) st.right_votes = st.right_votes + 4'd1;
                     st.vote_count = st.vote_count + 4'd1;
                  end
                  if (st.vote_count >= VOTE_SAMPLES) begin
                     vf               = st.front_votes >= VOTE_MIN_HITS;
                     vl               = st.left_votes >= VOTE_MIN_HITS;
                     vr               = st.right_votes >= VOTE_MIN_HITS;
                     st.voting_active = 1'b0;
                     // boxed in on all sides or on both sides: stay put, next tick votes afresh
                     if (!(vf && vl && vr)) begin
                        if (vl && !vr) begin
                           st.side_right = 1'b1;
                           go_pass       = 1'b1;
                        end else if (vr && !vl) begin
                           st.side_right = 1'b0;
                           go_pass       = 1'b1;
                        end else if (vf && !vl && !vr) begin
                           st.side_right = 1'b0;
                           go_pass       = 1'b1;
                        end else if (!vf && !vl && !vr) begin
                           st      = clear_votes(st);
                           st.mode = MODE_CRUISE;
                        end
                     end
                     if (go_pass) begin
                        st                = clear_votes(st);
                        st.mode           = MODE_PASS;
                        st.stage          = STAGE_PIVOT1;
                        st.stage_start_ms = item.now_ms;
                     end
                  end
               end
               MODE_PASS: begin
                  duty = FULL_DUTY;
                  case (st.stage)
                     STAGE_PIVOT1, STAGE_ALIGN: begin
                        st.left_dir  = st.side_right ? DIR_FWD : DIR_REV;
                        st.right_dir = st.side_right ? DIR_REV : DIR_FWD;
                     end
                     STAGE_PIVOT2, STAGE_PIVOT3: begin
                        st.left_dir  = st.side_right ? DIR_REV : DIR_FWD;
                        st.right_dir = st.side_right ? DIR_FWD : DIR_REV;
                     end
                     STAGE_STRAIGHT1, STAGE_STRAIGHT2, STAGE_STRAIGHT3: begin
                        st.left_dir  = DIR_FWD;
                        st.right_dir = DIR_FWD;
                     end
                     default: begin
                        duty = 8'd0;
                        if (f_blk) begin
                           st.mode = MODE_VOTE;
                        end else begin
                           st      = clear_votes(st);
                           st.mode = MODE_CRUISE;
                        end
                     end
                  endcase
                  case (st.stage)
                     STAGE_PIVOT1: begin
                        if (elapsed >= {16'd0, cfg.turn_ms}) begin
                           st.stage          = STAGE_STRAIGHT1;
                           st.stage_start_ms = item.now_ms;
                        end
                     end
                     STAGE_STRAIGHT1: begin
                        if (elapsed >= {16'd0, cfg.straight_one_ms}) begin
                           st.stage          = STAGE_PIVOT2;
                           st.stage_start_ms = item.now_ms;
                        end
                     end
                     STAGE_PIVOT2: begin
                        if (elapsed >= {16'd0, cfg.turn_ms}) begin
                           st.stage          = STAGE_STRAIGHT2;
                           st.stage_start_ms = item.now_ms;
                        end
                     end
                     STAGE_STRAIGHT2: begin
                        if (elapsed >= {16'd0, cfg.straight_two_ms}) begin
                           st.stage          = STAGE_PIVOT3;
                           st.stage_start_ms = item.now_ms;
                        end
                     end
                     STAGE_PIVOT3: begin
                        if (elapsed >= {16'd0, cfg.turn_ms}) begin
                           st.stage          = STAGE_STRAIGHT3;
                           st.stage_start_ms = item.now_ms;
                        end
                     end
                     STAGE_STRAIGHT3: begin
                        if (elapsed >= {16'd0, cfg.straight_three_ms}) begin
                           st.stage          = STAGE_ALIGN;
                           st.stage_start_ms = item.now_ms;
                        end
                     end
                     STAGE_ALIGN: begin
                        if (elapsed >= {16'd0, cfg.align_ms}) begin
                           st.stage          = STAGE_DONE;
                           st.stage_start_ms = item.now_ms;
                        end
                     end
                     default: begin
                        st.stage = STAGE_DONE;
                     end
                  endcase
               end
               default: begin
                  duty = 8'd0;
               end
            endcase
         end
      end
   end

   assign nxt = st;

   always_comb begin
      res.left_pwm       = duty;
      res.left_dir       = st.left_dir;
      res.right_pwm      = duty;
      res.right_dir      = st.right_dir;
      res.led_on         = st.led;
      res.mode_now       = st.mode;
      res.pass_stage_now = st.stage;
      res.pass_to_right  = st.side_right;
   end

endmodule

/* hw/rtl/obstacle_avoid_pass_sequencer_core.sv */
// ----------------------------------------------------------------------------
// obstacle_avoid_pass_sequencer_core
// Drive sequencer: boot hold, run/stop button, cruise, obstacle vote, pass.
// ----------------------------------------------------------------------------
//  channel  | ports     | direction | beat
//  ---------+-----------+-----------+----------------------------------------
//  request  | req_*     | in        | one control tick (time, button, echoes)
//  response | rsp_*     | out       | motor duty/dir, lamp, mode, pass status
//  config   | csr_*     | in        | one register write, no handshake
//
//  One beat per clock sustained while the response side is ready. A request
//  beat lands in the input register; the step logic then works on it and
//  loads the response register once the response side can take it.
//  Reset clears the sequencer state and config to defaults.
//  A stalled response holds the step; the input register keeps taking beats
//  while it is empty or advancing.
// ----------------------------------------------------------------------------
module obstacle_avoid_pass_sequencer_core
   import obspass_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [31:0]           req_now_ms,
   input  logic                  req_button_level,
   input  logic [14:0]           req_echo_front_us,
   input  logic [14:0]           req_echo_left_us,
   input  logic [14:0]           req_echo_right_us,

   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [7:0]            rsp_left_pwm,
   output logic [1:0]            rsp_left_dir,
   output logic [7:0]            rsp_right_pwm,
   output logic [1:0]            rsp_right_dir,
   output logic                  rsp_led_on,
   output logic [1:0]            rsp_mode_now,
   output logic [2:0]            rsp_pass_stage_now,
   output logic                  rsp_pass_to_right,

   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type    cfg;
   item_type   item_ff;
   item_type   item_in;
   logic       in_vld_ff;
   logic       in_vld_in;
   state_type  state_ff;
   state_type  state_nxt;
   result_type res_ff;
   result_type res_nxt;
   logic       rsp_vld_ff;
   logic       rsp_vld_in;
   logic       advance;
   logic       req_take;

   obspass_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   obspass_step u_step (
      .cfg  (cfg),
      .item (item_ff),
      .cur  (state_ff),
      .nxt  (state_nxt),
      .res  (res_nxt)
   );

   assign advance   = in_vld_ff && (!rsp_vld_ff || rsp_ready);
   assign req_ready = !in_vld_ff || advance;
   assign req_take  = req_valid && req_ready;

   assign in_vld_in  = req_take || (in_vld_ff && !advance);
   assign rsp_vld_in = advance || (rsp_vld_ff && !rsp_ready);

   always_comb begin
      item_in.now_ms        = req_now_ms;
      item_in.button_level  = req_button_level;
      item_in.echo_front_us = req_echo_front_us;
      item_in.echo_left_us  = req_echo_left_us;
      item_in.echo_right_us = req_echo_right_us;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         item_ff <= item_in;
      end
      if (advance) begin
         res_ff <= res_nxt;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.system_on      <= 1'b0;
         state_ff.prev_button    <= 1'b1;
         state_ff.mode           <= MODE_IDLE;
         state_ff.stage          <= STAGE_DONE;
         state_ff.side_right     <= 1'b0;
         state_ff.stage_start_ms <= '0;
         state_ff.voting_active  <= 1'b0;
         state_ff.vote_count     <= '0;
         state_ff.front_votes    <= '0;
         state_ff.left_votes     <= '0;
         state_ff.right_votes    <= '0;
         state_ff.last_vote_ms   <= '0;
         state_ff.vote_taken     <= 1'b0;
         state_ff.left_dir       <= DIR_OFF;
         state_ff.right_dir      <= DIR_OFF;
         state_ff.led            <= 1'b0;
      end else if (advance) begin
         state_ff <= state_nxt;
      end
   end

   assign rsp_valid          = rsp_vld_ff;
   assign rsp_left_pwm       = res_ff.left_pwm;
   assign rsp_left_dir       = res_ff.left_dir;
   assign rsp_right_pwm      = res_ff.right_pwm;
   assign rsp_right_dir      = res_ff.right_dir;
   assign rsp_led_on         = res_ff.led_on;
   assign rsp_mode_now       = res_ff.mode_now;
   assign rsp_pass_stage_now = res_ff.pass_stage_now;
   assign rsp_pass_to_right  = res_ff.pass_to_right;

endmodule

/* tb/tb_obstacle_avoid_pass_sequencer_core.sv */
// ----------------------------------------------------------------------------
// tb_obstacle_avoid_pass_sequencer_core
// Self-checking bench for the drive sequencer. A short table of control ticks
// covers the boot hold, run/stop toggling, cruise, a full vote and a complete
// pass. Random ticks follow under several register settings. Every response beat
// is checked field by field against a typed result or a cycle-free sequencer model.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_obstacle_avoid_pass_sequencer_core
   import obspass_pkg::*;
();

   localparam int CYCLE_LIMIT = 400000;
   localparam int SHOW_LIMIT  = 200;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic [31:0]           req_now_ms;
   logic                  req_button_level;
   logic [14:0]           req_echo_front_us;
   logic [14:0]           req_echo_left_us;
   logic [14:0]           req_echo_right_us;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic [7:0]            rsp_left_pwm;
   logic [1:0]            rsp_left_dir;
   logic [7:0]            rsp_right_pwm;
   logic [1:0]            rsp_right_dir;
   logic                  rsp_led_on;
   logic [1:0]            rsp_mode_now;
   logic [2:0]            rsp_pass_stage_now;
   logic                  rsp_pass_to_right;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   typedef struct {
      item_type   tick;
      bit         typed;
      result_type want;
   } plan_row_type;

   plan_row_type plan_rows[$];
   result_type   drive_results_due[$];
   result_type   due;
   result_type   seen;

   // sequencer model state
   cfg_type    drive_cfg;
   state_type  drive_st;
   logic [7:0] duty_left;
   logic [7:0] duty_right;

   // stimulus state
   logic [31:0] tick_ms;
   logic        btn_now;
   logic [2:0]  scene;        // front, left, right obstacle present
   bit          idle_on;
   int          hold_left;
   int          mismatches;
   int          beat_no;
   int          cycles = 0;

   obstacle_avoid_pass_sequencer_core uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_now_ms         (req_now_ms),
      .req_button_level   (req_button_level),
      .req_echo_front_us  (req_echo_front_us),
      .req_echo_left_us   (req_echo_left_us),
      .req_echo_right_us  (req_echo_right_us),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_left_pwm       (rsp_left_pwm),
      .rsp_left_dir       (rsp_left_dir),
      .rsp_right_pwm      (rsp_right_pwm),
      .rsp_right_dir      (rsp_right_dir),
      .rsp_led_on         (rsp_led_on),
      .rsp_mode_now       (rsp_mode_now),
      .rsp_pass_stage_now (rsp_pass_stage_now),
      .rsp_pass_to_right  (rsp_pass_to_right),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles = cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("tb_obstacle_avoid_pass_sequencer_core failed");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // sequencer model
   // ------------------------------------------------------------------------
   function automatic bit echo_near(input logic [14:0] us, input logic [14:0] lim);
      return (us != 15'd0) && (us <= lim);
   endfunction

   function automatic void stop_motors();
      duty_left  = 8'd0;
      duty_right = 8'd0;
   endfunction

   function automatic void motors(input logic [1:0] ld, input logic [1:0] rd,
                                  input logic [7:0] duty);
      drive_st.left_dir  = ld;
      drive_st.right_dir = rd;
      duty_left          = duty;
      duty_right         = duty;
   endfunction

   function automatic void spin(input bit to_right);
      if (to_right) motors(DIR_FWD, DIR_REV, FULL_DUTY);
      else motors(DIR_REV, DIR_FWD, FULL_DUTY);
   endfunction

   function automatic void enter_mode(input logic [1:0] m);
      drive_st.mode = m;
      if (m != MODE_VOTE) begin
         drive_st.voting_active = 1'b0;
         drive_st.vote_count    = '0;
         drive_st.front_votes   = '0;
         drive_st.left_votes    = '0;
         drive_st.right_votes   = '0;
         drive_st.vote_taken    = 1'b0;
      end
   endfunction

   function automatic result_type next_drive_result(input item_type it);
      logic [31:0] span;
      logic [31:0] lim;
      bit          fb, lb, rb, go;
      result_type  res;
      if (it.now_ms < STARTUP_WAIT_MS) begin
         stop_motors();
      end else begin
         if (drive_st.prev_button && !it.button_level) begin
            drive_st.system_on = !drive_st.system_on;
            if (!drive_st.system_on) begin
               // off: vote counters are left untouched
               drive_st.mode = MODE_IDLE;
               stop_motors();
               drive_st.led = 1'b0;
            end else begin
               enter_mode(MODE_CRUISE);
               drive_st.led = 1'b1;
            end
         end
         drive_st.prev_button = it.button_level;
         if (!drive_st.system_on) begin
            stop_motors();
         end else begin
            case (drive_st.mode)
               MODE_CRUISE: begin
                  if (echo_near(it.echo_front_us, drive_cfg.front_stop_us) ||
                      echo_near(it.echo_left_us, drive_cfg.side_clear_us) ||
                      echo_near(it.echo_right_us, drive_cfg.side_clear_us)) begin
                     stop_motors();
                     enter_mode(MODE_VOTE);
                  end else begin
                     motors(DIR_FWD, DIR_FWD, drive_cfg.fwd_duty);
                  end
               end
               MODE_VOTE: begin
                  stop_motors();
                  if (!drive_st.voting_active) begin
                     drive_st.voting_active = 1'b1;
                     drive_st.vote_count    = '0;
                     drive_st.front_votes   = '0;
                     drive_st.left_votes    = '0;
                     drive_st.right_votes   = '0;
                     drive_st.vote_taken    = 1'b0;
                  end
                  span = it.now_ms - drive_st.last_vote_ms;
                  if (!drive_st.vote_taken || span >= VOTE_GAP_MS) begin
                     drive_st.last_vote_ms = it.now_ms;
                     drive_st.vote_taken   = 1'b1;
                     if (echo_near(it.echo_front_us, drive_cfg.front_stop_us))
                        drive_st.front_votes = drive_st.front_votes + 4'd1;
                     if (echo_near(it.echo_left_us, drive_cfg.side_clear_us))
                        drive_st.left_votes = drive_st.left_votes + 4'd1;
                     if (echo_near(it.echo_right_us, drive_cfg.side_clear_us))
                        drive_st.right_votes = drive_st.right_votes + 4'd1;
                     drive_st.vote_count = drive_st.vote_count + 4'd1;
                  end
                  if (drive_st.vote_count >= VOTE_SAMPLES) begin
                     fb = drive_st.front_votes >= VOTE_MIN_HITS;
                     lb = drive_st.left_votes >= VOTE_MIN_HITS;
                     rb = drive_st.right_votes >= VOTE_MIN_HITS;
                     go = 1'b0;
                     drive_st.voting_active = 1'b0;
                     // everything blocked or both sides blocked: stay, revote
                     if (!(fb && lb && rb)) begin
                        if (lb && !rb) begin
                           drive_st.side_right = 1'b1;
                           go = 1'b1;
                        end else if (rb && !lb) begin
                           drive_st.side_right = 1'b0;
                           go = 1'b1;
                        end else if (fb && !lb && !rb) begin
                           drive_st.side_right = 1'b0;
                           go = 1'b1;
                        end else if (!fb && !lb && !rb) begin
                           enter_mode(MODE_CRUISE);
                        end
                     end
                     if (go) begin
                        enter_mode(MODE_PASS);
                        drive_st.stage          = STAGE_PIVOT1;
                        drive_st.stage_start_ms = it.now_ms;
                     end
                  end
               end
               MODE_PASS: begin
                  span = it.now_ms - drive_st.stage_start_ms;
                  lim  = 32'd0;
                  case (drive_st.stage)
                     STAGE_PIVOT1: begin
                        spin(drive_st.side_right);
                        lim = {16'd0, drive_cfg.turn_ms};
                     end
                     STAGE_STRAIGHT1: begin
                        motors(DIR_FWD, DIR_FWD, FULL_DUTY);
                        lim = {16'd0, drive_cfg.straight_one_ms};
                     end
                     STAGE_PIVOT2, STAGE_PIVOT3: begin
                        spin(!drive_st.side_right);
                        lim = {16'd0, drive_cfg.turn_ms};
                     end
                     STAGE_STRAIGHT2: begin
                        motors(DIR_FWD, DIR_FWD, FULL_DUTY);
                        lim = {16'd0, drive_cfg.straight_two_ms};
                     end
                     STAGE_STRAIGHT3: begin
                        motors(DIR_FWD, DIR_FWD, FULL_DUTY);
                        lim = {16'd0, drive_cfg.straight_three_ms};
                     end
                     STAGE_ALIGN: begin
                        spin(drive_st.side_right);
                        lim = {16'd0, drive_cfg.align_ms};
                     end
                     default: begin
                        stop_motors();
                        if (echo_near(it.echo_front_us, drive_cfg.front_stop_us))
                           enter_mode(MODE_VOTE);
                        else
                           enter_mode(MODE_CRUISE);
                     end
                  endcase
                  if (drive_st.stage != STAGE_DONE && span >= lim) begin
                     drive_st.stage          = drive_st.stage + 3'd1;
                     drive_st.stage_start_ms = it.now_ms;
                  end
               end
               default: stop_motors();
            endcase
         end
      end
      res = {duty_left, drive_st.left_dir, duty_right, drive_st.right_dir, drive_st.led,
             drive_st.mode, drive_st.stage, drive_st.side_right};
      return res;
   endfunction

   // ------------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------------
   function automatic item_type mk_tick(input logic [31:0] now, input logic btn,
                                        input logic [14:0] f, input logic [14:0] l,
                                        input logic [14:0] r);
      item_type it;
      it = {now, btn, f, l, r};
      return it;
   endfunction

   function automatic void plan(input item_type it, input bit typed, input result_type want);
      plan_row_type row;
      row.tick  = it;
      row.typed = typed;
      row.want  = want;
      plan_rows.push_back(row);
   endfunction

   function automatic logic [14:0] pick_echo(input bit near, input logic [14:0] thr);
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (near && thr != 15'd0) begin
         if (roll < 10) return thr;
         return 15'($urandom_range(1, thr));
      end
      if (roll < 35) return 15'd0;
      if (roll < 85 && thr < 15'd30000) return 15'($urandom_range(thr + 1, 30000));
      return 15'($urandom());
   endfunction

   task automatic make_tick(output item_type it);
      int unsigned roll;
      roll = $urandom_range(0, 999);
      if (roll < 5) tick_ms = $urandom_range(0, 999);     // back into the boot hold
      else if (roll < 10) tick_ms = $urandom();
      else if (roll < 15) tick_ms = 32'hFFFF_FFFF - $urandom_range(0, 200);
      else if (roll < 35) tick_ms = tick_ms + $urandom_range(0, 70000);
      else if (roll < 100) tick_ms = tick_ms + $urandom_range(100, 3000);
      else tick_ms = tick_ms + $urandom_range(0, 40);

      if (!btn_now) btn_now = 1'($urandom_range(0, 1));
      else if (!drive_st.system_on) btn_now = ($urandom_range(0, 4) != 0);
      else btn_now = ($urandom_range(0, 149) != 0);

      if ($urandom_range(0, 19) == 0)
         scene = ($urandom_range(0, 9) < 3) ? 3'd0 : 3'($urandom_range(1, 7));

      it = mk_tick(tick_ms, btn_now,
                   pick_echo(scene[2] ^ ($urandom_range(0, 99) < 12), drive_cfg.front_stop_us),
                   pick_echo(scene[1] ^ ($urandom_range(0, 99) < 12), drive_cfg.side_clear_us),
                   pick_echo(scene[0] ^ ($urandom_range(0, 99) < 12), drive_cfg.side_clear_us));
   endtask

   task automatic push_tick(input item_type it, input bit typed, input result_type want);
      int gap;
      result_type res;
      gap = 0;
      if (idle_on && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 13);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid         <= 1'b1;
      req_now_ms        <= it.now_ms;
      req_button_level  <= it.button_level;
      req_echo_front_us <= it.echo_front_us;
      req_echo_left_us  <= it.echo_left_us;
      req_echo_right_us <= it.echo_right_us;
      do @(posedge clock); while (req_ready !== 1'b1);
      res = next_drive_result(it);
      drive_results_due.push_back(typed ? want : res);
   endtask

   task automatic csr_put(input logic [CSR_IDX_W-1:0] idx, input logic [15:0] data);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      case (idx)
         CSR_FRONT_STOP:     drive_cfg.front_stop_us     = data[14:0];
         CSR_SIDE_CLEAR:     drive_cfg.side_clear_us     = data[14:0];
         CSR_FWD_DUTY:       drive_cfg.fwd_duty          = data[7:0];
         CSR_PIVOT:          drive_cfg.turn_ms           = data;
         CSR_STRAIGHT_ONE:   drive_cfg.straight_one_ms   = data;
         CSR_STRAIGHT_TWO:   drive_cfg.straight_two_ms   = data;
         CSR_STRAIGHT_THREE: drive_cfg.straight_three_ms = data;
         CSR_FINAL_ALIGN:    drive_cfg.align_ms          = data;
         default: ;
      endcase
   endtask

   // drop valid, wait out every response, then the two-stage pipe
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (drive_results_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic run_phase(input logic [15:0] fs, input logic [15:0] sc,
                            input logic [15:0] cp, input logic [15:0] pv,
                            input logic [15:0] s1, input logic [15:0] s2,
                            input logic [15:0] s3, input logic [15:0] fa,
                            input int items, input bit calm);
      item_type it;
      settle();
      csr_put(CSR_FRONT_STOP, fs);
      csr_put(CSR_SIDE_CLEAR, sc);
      csr_put(CSR_FWD_DUTY, cp);
      csr_put(CSR_PIVOT, pv);
      csr_put(CSR_STRAIGHT_ONE, s1);
      csr_put(CSR_STRAIGHT_TWO, s2);
      csr_put(CSR_STRAIGHT_THREE, s3);
      csr_put(CSR_FINAL_ALIGN, fa);
      @(negedge clock);
      csr_wr_en <= 1'b0;
      idle_on = !calm;
      for (int n = 0; n < items; n++) begin
         make_tick(it);
         push_tick(it, 1'b0, '0);
         if (!calm && $urandom_range(0, 59) == 0) idle_on = !idle_on;
      end
   endtask

   // ------------------------------------------------------------------------
   // response side
   // ------------------------------------------------------------------------
   task automatic flag_mismatch(input string what, input int unsigned got,
                                input int unsigned want);
      mismatches = mismatches + 1;
      if (mismatches <= SHOW_LIMIT)
         $display("[%0t] beat %0d: %s got %0d expected %0d", $time, beat_no, what, got, want);
   endtask

   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
         hold_left = $urandom_range(0, 12);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (drive_results_due.size() == 0) begin
            flag_mismatch("beat with nothing expected, mode", 32'(rsp_mode_now), 0);
         end else begin
            due  = drive_results_due.pop_front();
            seen = {rsp_left_pwm, rsp_left_dir, rsp_right_pwm, rsp_right_dir, rsp_led_on,
                    rsp_mode_now, rsp_pass_stage_now, rsp_pass_to_right};
            if (seen.left_pwm !== due.left_pwm)
               flag_mismatch("left_pwm", 32'(seen.left_pwm), 32'(due.left_pwm));
            if (seen.left_dir !== due.left_dir)
               flag_mismatch("left_dir", 32'(seen.left_dir), 32'(due.left_dir));
            if (seen.right_pwm !== due.right_pwm)
               flag_mismatch("right_pwm", 32'(seen.right_pwm), 32'(due.right_pwm));
            if (seen.right_dir !== due.right_dir)
               flag_mismatch("right_dir", 32'(seen.right_dir), 32'(due.right_dir));
            if (seen.led_on !== due.led_on)
               flag_mismatch("led_on", 32'(seen.led_on), 32'(due.led_on));
            if (seen.mode_now !== due.mode_now)
               flag_mismatch("mode_now", 32'(seen.mode_now), 32'(due.mode_now));
            if (seen.pass_stage_now !== due.pass_stage_now)
               flag_mismatch("pass_stage_now", 32'(seen.pass_stage_now),
                             32'(due.pass_stage_now));
            if (seen.pass_to_right !== due.pass_to_right)
               flag_mismatch("pass_to_right", 32'(seen.pass_to_right),
                             32'(due.pass_to_right));
         end
         beat_no = beat_no + 1;
      end
   end

   // ------------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------------
   initial begin
      result_type  r_off, r_run, r_halt;
      logic [31:0] t;
      int unsigned stage_len [7];

      reset             = 1'b1;
      req_valid         = 1'b0;
      req_now_ms        = '0;
      req_button_level  = 1'b1;
      req_echo_front_us = '0;
      req_echo_left_us  = '0;
      req_echo_right_us = '0;
      rsp_ready         = 1'b1;
      csr_wr_en         = 1'b0;
      csr_index         = CSR_FRONT_STOP;
      csr_wdata         = '0;
      mismatches        = 0;
      beat_no           = 0;
      hold_left         = 0;
      idle_on           = 1'b1;
      tick_ms           = 32'd20000;
      btn_now           = 1'b1;
      scene             = 3'd0;

      drive_cfg.front_stop_us     = 15'd1632;
      drive_cfg.side_clear_us     = 15'd1632;
      drive_cfg.fwd_duty          = 8'd255;
      drive_cfg.turn_ms           = 16'd850;
      drive_cfg.straight_one_ms   = 16'd1100;
      drive_cfg.straight_two_ms   = 16'd1400;
      drive_cfg.straight_three_ms = 16'd1100;
      drive_cfg.align_ms          = 16'd650;
      drive_st             = '0;
      drive_st.prev_button = 1'b1;
      drive_st.mode        = MODE_IDLE;
      drive_st.stage       = STAGE_DONE;
      drive_st.left_dir    = DIR_OFF;
      drive_st.right_dir   = DIR_OFF;
      duty_left            = 8'd0;
      duty_right           = 8'd0;

      r_off  = {8'd0, DIR_OFF, 8'd0, DIR_OFF, 1'b0, MODE_IDLE, STAGE_DONE, 1'b0};
      r_run  = {8'd255, DIR_FWD, 8'd255, DIR_FWD, 1'b1, MODE_CRUISE, STAGE_DONE, 1'b0};
      r_halt = {8'd0, DIR_FWD, 8'd0, DIR_FWD, 1'b1, MODE_VOTE, STAGE_DONE, 1'b0};

      // boot hold ignores the button, then press to run, cruise, front obstacle
      plan(mk_tick(32'd0, 1'b0, 15'd0, 15'd0, 15'd0), 1'b1, r_off);
      plan(mk_tick(32'd999, 1'b0, 15'd1, 15'd1, 15'd1), 1'b1, r_off);
      plan(mk_tick(32'hFFFF_FFFF, 1'b1, 15'd0, 15'd0, 15'd0), 1'b1, r_off);
      plan(mk_tick(32'd1010, 1'b0, 15'd0, 15'd0, 15'd0), 1'b1, r_run);
      plan(mk_tick(32'd1020, 1'b1, 15'h7FFF, 15'd30000, 15'd1633), 1'b1, r_run);
      plan(mk_tick(32'd1030, 1'b1, 15'd1632, 15'd0, 15'd0), 1'b1, r_halt);
      // vote: front and left blocked, one sample too early, pass to the right
      plan(mk_tick(32'd1040, 1'b1, 15'd1500, 15'd800, 15'd0), 1'b0, '0);
      plan(mk_tick(32'd1064, 1'b1, 15'd1500, 15'd800, 15'd0), 1'b0, '0);
      for (int k = 0; k < 9; k++)
         plan(mk_tick(32'd1065 + 25 * k, 1'b1, 15'd1500, 15'd800, 15'd0), 1'b0, '0);
      // each stage row lands exactly on its duration
      stage_len = '{850, 1100, 850, 1400, 850, 1100, 650};
      t = 32'd1265;
      for (int k = 0; k < 7; k++) begin
         t = t + stage_len[k];
         plan(mk_tick(t, 1'b1, 15'd0, 15'd0, 15'd0), 1'b0, '0);
      end
      plan(mk_tick(t + 10, 1'b1, 15'd0, 15'd0, 15'd0), 1'b0, '0);
      plan(mk_tick(t + 20, 1'b0, 15'd0, 15'd0, 15'd0), 1'b0, '0);

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (plan_rows[i]) push_tick(plan_rows[i].tick, plan_rows[i].typed, plan_rows[i].want);

      run_phase(16'($urandom_range(300, 6000)), 16'($urandom_range(300, 6000)),
                16'($urandom()), 16'($urandom_range(0, 120)),
                16'($urandom_range(0, 200)), 16'($urandom_range(0, 200)),
                16'($urandom_range(0, 200)), 16'($urandom_range(0, 100)), 250, 1'b0);
      // front never blocks, any side echo blocks, zero duty, zero-length stages
      run_phase(16'h0000, 16'hFFFF, 16'hFF00, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 150, 1'b0);
      // front blocks on any echo, sides never, longest stages
      run_phase(16'hFFFF, 16'h0000, 16'h00FF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                16'hFFFF, 150, 1'b0);
      run_phase(16'($urandom_range(500, 5000)), 16'($urandom_range(500, 5000)),
                16'($urandom()), 16'($urandom_range(0, 300)),
                16'($urandom_range(0, 300)), 16'($urandom_range(0, 300)),
                16'($urandom_range(0, 300)), 16'($urandom_range(0, 300)), 250, 1'b0);
      run_phase(16'($urandom_range(300, 6000)), 16'($urandom_range(300, 6000)),
                16'($urandom()), 16'($urandom_range(0, 120)),
                16'($urandom_range(0, 200)), 16'($urandom_range(0, 200)),
                16'($urandom_range(0, 200)), 16'($urandom_range(0, 100)), 250, 1'b1);

      settle();
      if (drive_results_due.size() != 0)
         flag_mismatch("results still due", drive_results_due.size(), 0);
      if (mismatches == 0) begin
         $display("tb_obstacle_avoid_pass_sequencer_core passed");
      end else begin
         $display("tb_obstacle_avoid_pass_sequencer_core failed");
      end
      $finish;
   end

endmodule

/* sim.f */
hw/rtl/obspass_pkg.sv
hw/rtl/obspass_csr.sv
hw/rtl/obspass_step.sv
hw/rtl/obstacle_avoid_pass_sequencer_core.sv
tb/tb_obstacle_avoid_pass_sequencer_core.sv
